@@ design/osa_pkg.sv @@
// Package for the operand stack ALU: transaction types, operation and error codes, defaults.
package osa_pkg;

	localparam int STACK_DEPTH = 256;
	localparam int WORD_WIDTH  = 32;

	typedef enum logic [2:0] {
		OP_PUSH = 3'd0,
		OP_POP  = 3'd1,
		OP_ADD  = 3'd2,
		OP_SUB  = 3'd3,
		OP_AND  = 3'd4,
		OP_OR   = 3'd5,
		OP_SWAP = 3'd6
	} op_t;

	typedef enum logic [1:0] {
		ERR_OK    = 2'd0,
		ERR_UNDER = 2'd1,
		ERR_OVER  = 2'd2
	} err_t;

	typedef struct packed {
		logic [2:0]         func;
		logic signed [31:0] push_word;
	} req_t;

	typedef struct packed {
		logic signed [31:0] top_word;
		logic [1:0]         error_code;
		logic [8:0]         depth_now;
	} rsp_t;

endpackage

@@ design/operand_stack_alu_unit.sv @@
// Operand stack with built-in ALU: top level.
//
// Usage: one request transaction on req (func, push_word) yields exactly one
// response transaction on rsp (top_word, error_code, depth_now). Both channels
// use valid/stall; a transaction moves when valid is high and stall is low.
//
// The top two words live in registers; deeper words live in a RAM of
// STACK_DEPTH-2 entries with registered read. A pop or binary operation issues
// a read for the new second word; its data is picked up in the following cycle,
// so no bubble is needed. The response is registered and appears in the cycle
// after the request is taken; while rsp_stall is low, one item per cycle is taken.
//
// Reset clears the depth to zero and empties the response register; the RAM is
// not cleared, since only written entries are ever read.
// When the receiver stalls a pending response, req_stall rises and the
// response holds until taken. Errors (overflow, underflow) leave the stack as
// it was and report top_word zero.
module operand_stack_alu_unit #(
	parameter int STACK_DEPTH = osa_pkg::STACK_DEPTH,
	parameter int WORD_WIDTH  = osa_pkg::WORD_WIDTH
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          req_valid,
	output logic          req_stall,
	input  osa_pkg::req_t req,
	output logic          rsp_valid,
	input  logic          rsp_stall,
	output osa_pkg::rsp_t rsp
);

	localparam int RAM_DEPTH = (STACK_DEPTH > 3) ? STACK_DEPTH - 2 : 2;
	localparam int AW        = $clog2(RAM_DEPTH);
	localparam int DW        = $clog2(STACK_DEPTH + 1);

	logic [WORD_WIDTH-1:0] top_q, second_q, second_eff, top_n, second_n;
	logic [WORD_WIDTH-1:0] word, push_val, rd_data, wr_data;
	logic [DW-1:0]         depth_q, depth_n;
	logic                  pending_q, rd_issue, we;
	logic [AW-1:0]         waddr, raddr;
	osa_pkg::err_t         err;
	logic                  accept, full, ge1, ge2, ge3;
	logic                  rsp_valid_q;
	osa_pkg::rsp_t         rsp_q;

	osa_ram #(.WIDTH(WORD_WIDTH), .DEPTH(RAM_DEPTH)) u_ram (
		.clk   (clk),
		.we    (we),
		.waddr (waddr),
		.wdata (wr_data),
		.raddr (raddr),
		.rdata (rd_data)
	);

	assign accept     = req_valid && !req_stall;
	assign req_stall  = rsp_valid_q && rsp_stall;
	assign rsp_valid  = rsp_valid_q;
	assign rsp        = rsp_q;

	// second word is still arriving from the RAM in the cycle after a pop or binary op
	assign second_eff = pending_q ? rd_data : second_q;
	assign push_val   = WORD_WIDTH'(req.push_word);
	assign full       = depth_q == DW'(STACK_DEPTH);
	assign ge1        = depth_q != '0;
	assign ge2        = depth_q > DW'(1);
	assign ge3        = depth_q > DW'(2);

	always_comb begin
		top_n    = top_q;
		second_n = second_eff;
		depth_n  = depth_q;
		we       = 1'b0;
		wr_data  = second_eff;
		waddr    = AW'(depth_q - DW'(2));
		raddr    = AW'(depth_q - DW'(3));
		rd_issue = 1'b0;
		word     = '0;
		err      = osa_pkg::ERR_OK;
		case (osa_pkg::op_t'(req.func))
			osa_pkg::OP_PUSH: begin
				if (full) begin
					err = osa_pkg::ERR_OVER;
				end else begin
					we       = ge2;
					second_n = top_q;
					top_n    = push_val;
					depth_n  = depth_q + DW'(1);
					word     = push_val;
				end
			end
			osa_pkg::OP_POP: begin
				if (!ge1) begin
					err = osa_pkg::ERR_UNDER;
				end else begin
					word     = top_q;
					top_n    = second_eff;
					depth_n  = depth_q - DW'(1);
					rd_issue = ge3;
				end
			end
			osa_pkg::OP_ADD, osa_pkg::OP_SUB, osa_pkg::OP_AND, osa_pkg::OP_OR: begin
				if (!ge2) begin
					err = osa_pkg::ERR_UNDER;
				end else begin
					case (osa_pkg::op_t'(req.func))
						osa_pkg::OP_ADD: word = second_eff + top_q;
						osa_pkg::OP_SUB: word = second_eff - top_q;
						osa_pkg::OP_AND: word = second_eff & top_q;
						default:         word = second_eff | top_q;
					endcase
					top_n    = word;
					depth_n  = depth_q - DW'(1);
					rd_issue = ge3;
				end
			end
			osa_pkg::OP_SWAP: begin
				if (!ge2) begin
					err = osa_pkg::ERR_UNDER;
				end else begin
					top_n    = second_eff;
					second_n = top_q;
					word     = second_eff;
				end
			end
			default: begin
				word = ge1 ? top_q : '0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			depth_q     <= '0;
			pending_q   <= 1'b0;
			rsp_valid_q <= 1'b0;
		end else begin
			if (accept) begin
				depth_q   <= depth_n;
				pending_q <= rd_issue;
			end else begin
				pending_q <= 1'b0;
			end
			if (!rsp_valid_q || !rsp_stall) begin
				rsp_valid_q <= accept;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			top_q              <= top_n;
			second_q           <= second_n;
			rsp_q.top_word     <= 32'(word);
			rsp_q.error_code   <= err;
			rsp_q.depth_now    <= 9'(depth_n);
		end else if (pending_q) begin
			second_q <= rd_data;
		end
	end

endmodule

@@ design/osa_ram.sv @@
// Generic single-write, single-read RAM with registered read data.
module osa_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 256
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule
